>>> sv/mpool_pkg.sv
`timescale 1ns / 1ps

package mpool_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxKernel  = 8;
    localparam int MaxHeight  = 4096;
    localparam int MaxResults = 25;
    localparam int StoreDepth = MaxKernel * MaxWidth;

    localparam int SampleBits = 16;
    localparam int RowBits    = 13;
    localparam int ColBits    = 11;
    localparam int InRowBits  = 12;
    localparam int InColBits  = 10;
    localparam int KBits      = 4;
    localparam int PadBits    = 3;
    localparam int CntBits    = 5;
    localparam int AddrBits   = $clog2(StoreDepth);
    localparam int LaneBits   = $clog2(MaxKernel);

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_HEIGHT   = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_KHEIGHT  = 3'd2,
        REG_KWIDTH   = 3'd3,
        REG_SROWS    = 3'd4,
        REG_SCOLS    = 3'd5,
        REG_PROWS    = 3'd6,
        REG_PCOLS    = 3'd7
    } reg_idx_t;

    typedef logic signed [18:0] coord_t;
    typedef logic signed [SampleBits-1:0] sample_t;

    localparam sample_t SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

    // effective (clamped) geometry
    typedef struct packed {
        logic [RowBits-1:0] h;
        logic [ColBits-1:0] w;
        logic [KBits-1:0]   kh;
        logic [KBits-1:0]   kw;
        logic [KBits-1:0]   sr;
        logic [KBits-1:0]   sc;
        logic [PadBits-1:0] pr;
        logic [PadBits-1:0] pc;
    } geom_t;

    typedef struct packed {
        logic accept;     // store sample, clear burst count
        logic calc;       // register window origin products
        logic row_adv;    // move to next output row
        logic scan_init;  // latch window bounds, reset maximum
        logic scan_step;  // issue one store read
        logic out_done;   // result transferred
        logic finish;     // update input counters
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic col_bad;
        logic not_due;
        logic empty;
        logic scan_last;
    } sts_t;

endpackage

>>> sv/max_pool_2d_stream.sv
`timescale 1ns / 1ps
// Streaming 2-D max pooling over one channel's feature map.
// Input: s_axis_* carries one signed 16-bit sample per transfer, raster order.
// Output: m_axis_* carries one pooled result per transfer, output raster
// order; tlast marks the frame's final result.
// Configuration: cfg_valid/cfg_index/cfg_data write one geometry register
// (height, width, kernel, stride, padding); cfg_ready is always high.
// Write configuration only between frames while the block is idle.
// Per sample with no result due: accept, product, test, counter update.
// Each result due adds a product, a test, a read of every real sample in its
// window one at a time from the single-port line store, a drain step and the
// transfer (no read or drain if its window holds no real sample); a skipped
// output row adds a product and a test; a stalled receiver adds its wait.
// The block takes one sample at a time; s_axis_tready drops until all the
// results that sample completes have been transferred.
// A stalled receiver simply holds the result and its fields stable.
// Reset: counters return to the frame start, geometry to 1x1 input with
// 2x2 kernel, stride 2, no padding. The line store is not cleared; every
// entry read in a frame has been written earlier in that frame.
module max_pool_2d_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [15:0] pooled_value, [28:16] out_row,
                                         // [39:29] out_col
    output logic        m_axis_tlast,    // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import mpool_pkg::*;

    // raw geometry registers as written
    logic [RowBits-1:0] height_reg;
    logic [ColBits-1:0] width_reg;
    logic [KBits-1:0]   kh_reg, kw_reg, sr_reg, sc_reg;
    logic [PadBits-1:0] pr_reg, pc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= RowBits'(1);
            width_reg  <= ColBits'(1);
            kh_reg     <= KBits'(2);
            kw_reg     <= KBits'(2);
            sr_reg     <= KBits'(2);
            sc_reg     <= KBits'(2);
            pr_reg     <= '0;
            pc_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_HEIGHT:  height_reg <= cfg_data[RowBits-1:0];
                REG_WIDTH:   width_reg  <= cfg_data[ColBits-1:0];
                REG_KHEIGHT: kh_reg     <= cfg_data[KBits-1:0];
                REG_KWIDTH:  kw_reg     <= cfg_data[KBits-1:0];
                REG_SROWS:   sr_reg     <= cfg_data[KBits-1:0];
                REG_SCOLS:   sc_reg     <= cfg_data[KBits-1:0];
                REG_PROWS:   pr_reg     <= cfg_data[PadBits-1:0];
                REG_PCOLS:   pc_reg     <= cfg_data[PadBits-1:0];
                default: ;
            endcase
        end
    end

    // clamp to what the line store and window logic support
    geom_t geom;

    always_comb
    begin
        if (height_reg == '0)
            geom.h = RowBits'(1);
        else if (height_reg > RowBits'(MaxHeight))
            geom.h = RowBits'(MaxHeight);
        else
            geom.h = height_reg;
        if (width_reg == '0)
            geom.w = ColBits'(1);
        else if (width_reg > ColBits'(MaxWidth))
            geom.w = ColBits'(MaxWidth);
        else
            geom.w = width_reg;
        geom.kh = (kh_reg > KBits'(MaxKernel)) ? KBits'(MaxKernel) : kh_reg;
        geom.kw = (kw_reg > KBits'(MaxKernel)) ? KBits'(MaxKernel) : kw_reg;
        geom.sr = (sr_reg == '0) ? KBits'(1) : sr_reg;
        geom.sc = (sc_reg == '0) ? KBits'(1) : sc_reg;
        geom.pr = pr_reg;
        geom.pc = pc_reg;
    end

    cmd_t    cmd;
    sts_t    sts;
    sample_t pooled_value;
    logic [RowBits-1:0] out_row;
    logic [ColBits-1:0] out_col;

    mpool_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mpool_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (s_axis_tdata),
        .pooled_value (pooled_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_col, out_row, pooled_value};

endmodule

>>> sv/mpool_ctrl.sv
`timescale 1ns / 1ps

module mpool_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  mpool_pkg::sts_t sts,
    output mpool_pkg::cmd_t cmd
);
    import mpool_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_EVAL,
        S_SCAN,
        S_DRAIN,
        S_OUT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.stop)
                    state_next = S_DONE;
                else if (sts.col_bad)
                begin
                    cmd.row_adv = 1'b1;
                    state_next  = S_CALC;
                end
                else if (sts.not_due)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = sts.empty ? S_OUT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = S_CALC;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/mpool_dp.sv
`timescale 1ns / 1ps

module mpool_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mpool_pkg::geom_t                        geom,
    input  mpool_pkg::cmd_t                         cmd,
    output mpool_pkg::sts_t                         sts,
    input  logic signed [mpool_pkg::SampleBits-1:0] sample,
    output logic signed [mpool_pkg::SampleBits-1:0] pooled_value,
    output logic [mpool_pkg::RowBits-1:0]           out_row,
    output logic [mpool_pkg::ColBits-1:0]           out_col,
    output logic                                    frame_last
);
    import mpool_pkg::*;

    sample_t mem [0:StoreDepth-1];

    logic [InRowBits-1:0] in_row_reg, in_row_next;
    logic [InColBits-1:0] in_col_reg, in_col_next;
    logic [RowBits-1:0]   orow_reg, orow_next;
    logic [ColBits-1:0]   ocol_reg, ocol_next;
    logic [CntBits-1:0]   n_reg, n_next;

    logic [16:0] ohs_reg;
    logic [14:0] ows_reg;

    logic [InRowBits-1:0] i_reg, i_end_reg;
    logic [InColBits-1:0] j_reg, j_start_reg, j_end_reg;
    sample_t rdata_reg, best_reg;
    logic    rvld_reg;
    logic    final_reg;

    // clamped input position
    logic [InRowBits-1:0] r;
    logic [InColBits-1:0] c;
    logic [RowBits-1:0]   hm1;
    logic [ColBits-1:0]   wm1;
    logic                 last;

    always_comb
    begin
        hm1 = geom.h - 1'b1;
        wm1 = geom.w - 1'b1;
        r   = ({1'b0, in_row_reg} > hm1) ? hm1[InRowBits-1:0] : in_row_reg;
        c   = ({1'b0, in_col_reg} > wm1) ? wm1[InColBits-1:0] : in_col_reg;
        last = ({1'b0, r} == hm1) && ({1'b0, c} == wm1);
    end

    // window geometry from registered products
    coord_t hspan, wspan, rs, re, cs, ce, tr, tc, ilo, ihi, jlo, jhi, rr, cc;
    logic   row_ok, col_ok, row_fin, col_fin;

    always_comb
    begin
        hspan = coord_t'(geom.h) + coord_t'(geom.pr) + coord_t'(geom.pr);
        wspan = coord_t'(geom.w) + coord_t'(geom.pc) + coord_t'(geom.pc);
        rs = coord_t'(ohs_reg) - coord_t'(geom.pr);
        re = rs + coord_t'(geom.kh) - coord_t'(1);
        cs = coord_t'(ows_reg) - coord_t'(geom.pc);
        ce = cs + coord_t'(geom.kw) - coord_t'(1);
        row_ok  = (coord_t'(ohs_reg) + coord_t'(geom.kh)) <= hspan;
        col_ok  = (coord_t'(ows_reg) + coord_t'(geom.kw)) <= wspan;
        row_fin = (coord_t'(ohs_reg) + coord_t'(geom.sr) + coord_t'(geom.kh)) > hspan;
        col_fin = (coord_t'(ows_reg) + coord_t'(geom.sc) + coord_t'(geom.kw)) > wspan;
        ihi = (re > coord_t'(hm1)) ? coord_t'(hm1) : re;
        jhi = (ce > coord_t'(wm1)) ? coord_t'(wm1) : ce;
        ilo = (rs < 0) ? coord_t'(0) : rs;
        jlo = (cs < 0) ? coord_t'(0) : cs;
        tr  = (ihi < 0) ? coord_t'(0) : ihi;
        tc  = (jhi < 0) ? coord_t'(0) : jhi;
        rr  = coord_t'(r);
        cc  = coord_t'(c);
    end

    assign sts.stop      = (n_reg == CntBits'(MaxResults)) || !row_ok;
    assign sts.col_bad   = !col_ok;
    assign sts.not_due   = !last && ((tr > rr) || ((tr == rr) && (tc > cc)));
    assign sts.empty     = (ilo > ihi) || (jlo > jhi);
    assign sts.scan_last = (i_reg == i_end_reg) && (j_reg == j_end_reg);

    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        n_next      = n_reg;
        if (cmd.accept)
            n_next = '0;
        if (cmd.row_adv)
        begin
            orow_next = orow_reg + 1'b1;
            ocol_next = '0;
        end
        if (cmd.out_done)
        begin
            ocol_next = ocol_reg + 1'b1;
            n_next    = n_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            if (last)
            begin
                in_row_next = '0;
                in_col_next = '0;
                orow_next   = '0;
                ocol_next   = '0;
            end
            else if ({1'b0, c} < wm1)
            begin
                in_row_next = r;
                in_col_next = c + 1'b1;
            end
            else
            begin
                in_row_next = r + 1'b1;
                in_col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            n_reg      <= '0;
            rvld_reg   <= 1'b0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            n_reg      <= n_next;
            rvld_reg   <= cmd.scan_step;
        end
    end

    // line store: write on accept, one read per scan step
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            mem[{r[LaneBits-1:0], c}] <= sample;
        if (cmd.scan_step)
            rdata_reg <= mem[{i_reg[LaneBits-1:0], j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            ohs_reg <= 17'(orow_reg) * 17'(geom.sr);
            ows_reg <= 15'(ocol_reg) * 15'(geom.sc);
        end
        if (cmd.scan_init)
        begin
            i_reg       <= ilo[InRowBits-1:0];
            j_reg       <= jlo[InColBits-1:0];
            j_start_reg <= jlo[InColBits-1:0];
            i_end_reg   <= ihi[InRowBits-1:0];
            j_end_reg   <= jhi[InColBits-1:0];
            final_reg   <= (row_fin && col_fin)
                           || (last && (n_reg == CntBits'(MaxResults - 1)));
            best_reg    <= SampleMin;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                if (j_reg == j_end_reg)
                begin
                    j_reg <= j_start_reg;
                    i_reg <= i_reg + 1'b1;
                end
                else
                    j_reg <= j_reg + 1'b1;
            end
            if (rvld_reg && (rdata_reg > best_reg))
                best_reg <= rdata_reg;
        end
    end

    assign pooled_value = best_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign frame_last   = final_reg;

endmodule
